FILE: hdl/fpct_pkg.sv
// Shared package for the frustum plane cull test block.
// Holds opcodes, datapath widths, the plane table and the MAC control type.
// No dependencies.
package fpct_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_CUBE  = 2'd2;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ELEM_W          = 32;
  localparam int MAT_DEPTH       = 16;
  localparam int COEF_W          = 33;
  localparam int OPA_W           = 35;
  localparam int OPB_W           = 17;
  localparam int ACC_W           = 68;
  localparam int HALF_SHIFT      = 16;
  localparam int NUM_PLANES      = 6;

  typedef struct packed {
    logic load;
    logic issue;
    logic high_half;
  } mac_ctrl_t;

  // Matrix column that is combined with column four for each plane.
  function automatic logic [1:0] plane_col(input logic [2:0] plane);
    logic [1:0] col;
    unique case (plane)
      3'd0, 3'd1: col = 2'd2;
      3'd2, 3'd3: col = 2'd0;
      3'd4, 3'd5: col = 2'd1;
      default:    col = 2'd0;
    endcase
    return col;
  endfunction

  // One when the plane adds the column, zero when it subtracts it.
  function automatic logic plane_add(input logic [2:0] plane);
    logic add;
    unique case (plane)
      3'd0, 3'd2, 3'd5: add = 1'b1;
      3'd1, 3'd3, 3'd4: add = 1'b0;
      default:          add = 1'b0;
    endcase
    return add;
  endfunction

endpackage

FILE: hdl/fpct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fpct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/fpct_mac.sv
// Shared multiply-accumulate unit: one 35x17 signed product per cycle,
// registered, then added into a wide accumulator. Depends on fpct_pkg.
module fpct_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fpct_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [fpct_pkg::ACC_W-1:0]    init,
  input  logic signed [fpct_pkg::OPA_W-1:0]    op_a,
  input  logic signed [fpct_pkg::OPB_W-1:0]    op_b,
  output logic signed [fpct_pkg::ACC_W-1:0]    acc
);

  localparam int PROD_W = fpct_pkg::OPA_W + fpct_pkg::OPB_W;

  logic signed [PROD_W-1:0]         prod;
  logic                             prod_vld;
  logic                             prod_high;
  logic signed [fpct_pkg::ACC_W-1:0] prod_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= op_a * op_b;
    prod_high <= ctrl.high_half;
  end

  always_comb begin
    prod_ext = fpct_pkg::ACC_W'(prod);
    if (prod_high) begin
      prod_ext = prod_ext <<< fpct_pkg::HALF_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= init;
    end else if (prod_vld) begin
      acc <= acc + prod_ext;
    end
  end

endmodule

FILE: hdl/frustum_plane_cull_test.sv
// Frustum culling against six planes taken from a stored view-projection matrix.
// A load transaction is an accept followed by four RAM writes. A point or cube
// test runs, for each plane, matrix RAM reads, then the shared multiply-accumulate
// unit (four products, two halves each), then a check. One item is in work at a time.
// Synchronous active-high reset empties the matrix (all entries read as zero
// until written) and drops any pending result.
// Depends on fpct_pkg, fpct_ram and fpct_mac.
module frustum_plane_cull_test #(
  parameter int COORD_WIDTH = fpct_pkg::COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // row_index[1:0], elem_col1[33:2], elem_col2[65:34], elem_col3[97:66],
  // elem_col4[129:98], pos_x[161:130], pos_y[193:162], pos_z[225:194],
  // half_size[256:226], zero fill above
  input  logic [263:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // inside_res[0], zero fill above
  output logic [7:0]   m_tdata
);

  localparam int EW       = fpct_pkg::ELEM_W;
  localparam int SX_WIDTH = (COORD_WIDTH < EW) ? COORD_WIDTH : EW;
  localparam int SX_SHIFT = EW - SX_WIDTH;
  localparam int AW       = $clog2(fpct_pkg::MAT_DEPTH);
  localparam int CW       = fpct_pkg::COEF_W;
  localparam int OW       = fpct_pkg::OPA_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  function automatic logic signed [EW-1:0] sext(input logic [EW-1:0] v);
    logic [EW-1:0] t;
    t = v << SX_SHIFT;
    return $signed(t) >>> SX_SHIFT;
  endfunction

  logic [2:0]                state;
  logic [3:0]                cnt;
  logic [2:0]                plane;
  logic                      fail;
  logic [fpct_pkg::MAT_DEPTH-1:0] valid;
  logic                      rd_valid;
  logic                      visible;

  logic [1:0]                item_row;
  logic signed [EW-1:0]      ld [4];
  logic signed [EW-1:0]      pos [3];
  logic signed [EW-1:0]      rad;
  logic signed [EW-1:0]      elem_hold;
  logic signed [CW-1:0]      coef [4];
  logic [OW-1:0]             abs_sum;

  logic                      accept;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [EW-1:0]             wdata;
  logic [AW-1:0]             raddr;
  logic [EW-1:0]             rdata;
  logic signed [EW-1:0]      rd_eff;
  logic [3:0]                k;
  logic signed [CW-1:0]      coef_new;
  logic [CW-1:0]             coef_mag;

  fpct_pkg::mac_ctrl_t                    mac_ctrl;
  logic signed [fpct_pkg::ACC_W-1:0]      mac_init;
  logic signed [OW-1:0]                   op_a;
  logic signed [EW-1:0]                   op_b_full;
  logic signed [fpct_pkg::OPB_W-1:0]      op_b;
  logic signed [fpct_pkg::ACC_W-1:0]      acc;
  logic [1:0]                             pi;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {7'd0, visible};

  // Matrix write during a load.
  assign we    = (state == S_LOAD);
  assign waddr = {item_row, cnt[1:0]};
  assign wdata = ld[cnt[1:0]];

  // Matrix read during a plane fetch: even steps read the plane's column,
  // odd steps read column four of the same row.
  assign raddr  = {cnt[2:1], cnt[0] ? 2'd3 : fpct_pkg::plane_col(plane)};
  assign rd_eff = rd_valid ? $signed(rdata) : '0;
  assign k      = cnt - 4'd1;

  always_comb begin
    if (fpct_pkg::plane_add(plane)) begin
      coef_new = CW'(rd_eff) + CW'(elem_hold);
    end else begin
      coef_new = CW'(rd_eff) - CW'(elem_hold);
    end
    coef_mag = coef_new[CW-1] ? CW'(-coef_new) : CW'(coef_new);
  end

  // Operand selection for the shared MAC: the corner term of a cube uses the
  // sum of the coefficient magnitudes times the half extent.
  assign pi = cnt[2:1];

  always_comb begin
    mac_ctrl.load      = (state == S_MUL) && (cnt == 4'd0);
    mac_ctrl.issue     = (state == S_MUL) && !cnt[3];
    mac_ctrl.high_half = cnt[0];
    mac_init           = fpct_pkg::ACC_W'(coef[3]) <<< fpct_pkg::HALF_SHIFT;
    unique case (pi)
      2'd0: begin
        op_a      = OW'(coef[0]);
        op_b_full = pos[0];
      end
      2'd1: begin
        op_a      = OW'(coef[1]);
        op_b_full = pos[1];
      end
      2'd2: begin
        op_a      = OW'(coef[2]);
        op_b_full = pos[2];
      end
      2'd3: begin
        op_a      = $signed(abs_sum);
        op_b_full = rad;
      end
      default: begin
        op_a      = '0;
        op_b_full = '0;
      end
    endcase
    if (cnt[0]) begin
      op_b = {op_b_full[EW-1], op_b_full[EW-1:fpct_pkg::HALF_SHIFT]};
    end else begin
      op_b = {1'b0, op_b_full[fpct_pkg::HALF_SHIFT-1:0]};
    end
  end

  fpct_ram #(
    .WIDTH(EW),
    .DEPTH(fpct_pkg::MAT_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  fpct_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctrl(mac_ctrl),
    .init(mac_init),
    .op_a(op_a),
    .op_b(op_b),
    .acc (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      plane    <= '0;
      fail     <= 1'b0;
      valid    <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_valid <= valid[raddr];
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            plane <= '0;
            fail  <= 1'b0;
            case (s_tuser)
              fpct_pkg::OP_LOAD:  state <= S_LOAD;
              fpct_pkg::OP_POINT,
              fpct_pkg::OP_CUBE:  state <= S_FETCH;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          valid[waddr] <= 1'b1;
          cnt          <= cnt + 4'd1;
          if (cnt == 4'd3) begin
            state <= S_IDLE;
          end
        end
        S_FETCH: begin
          if (cnt == 4'd8) begin
            cnt   <= '0;
            state <= S_MUL;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_MUL: begin
          if (cnt == 4'd8) begin
            cnt   <= '0;
            state <= S_CHECK;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_CHECK: begin
          if (acc[fpct_pkg::ACC_W-1]) begin
            fail <= 1'b1;
          end
          if (plane == 3'(fpct_pkg::NUM_PLANES - 1)) begin
            state <= S_OUT;
          end else begin
            plane <= plane + 3'd1;
            state <= S_FETCH;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_row <= s_tdata[1:0];
      ld[0]    <= sext(s_tdata[33:2]);
      ld[1]    <= sext(s_tdata[65:34]);
      ld[2]    <= sext(s_tdata[97:66]);
      ld[3]    <= sext(s_tdata[129:98]);
      pos[0]   <= sext(s_tdata[161:130]);
      pos[1]   <= sext(s_tdata[193:162]);
      pos[2]   <= sext(s_tdata[225:194]);
      if (s_tuser == fpct_pkg::OP_CUBE) begin
        rad <= $signed({1'b0, s_tdata[256:226]});
      end else begin
        rad <= '0;
      end
    end
    if (state == S_FETCH) begin
      if (cnt == 4'd0) begin
        abs_sum <= '0;
      end else if (!k[0]) begin
        elem_hold <= rd_eff;
      end else begin
        coef[k[2:1]] <= coef_new;
        if (k[2:1] != 2'd3) begin
          abs_sum <= abs_sum + OW'(coef_mag);
        end
      end
    end
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      visible <= !fail;
    end
  end

endmodule

FILE: tb/tb_frustum_plane_cull_test.sv
// Self-checking testbench for frustum_plane_cull_test: loads matrix rows, runs point
// and cube tests, predicts each inside flag exactly and checks the result stream.
// Depends on fpct_pkg and the frustum_plane_cull_test RTL.
module tb_frustum_plane_cull_test;

  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [31:0] ONE       = 32'h0001_0000;
  localparam int          NUM_ITEMS = 1800;

  class cull_scoreboard;
    logic signed [31:0] matrix [16];
    bit expected_inside [$];
    int errors;

    function new();
      foreach (matrix[i]) matrix[i] = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_inside.size();
    endfunction

    // Whether the exact Q32.32 dot value of the plane (column four plus or minus column col) is non-negative.
    function bit plane_passes(int col, bit add, logic signed [79:0] px,
                              logic signed [79:0] py, logic signed [79:0] pz);
      logic signed [79:0] coef [4];
      logic signed [79:0] w, e;
      for (int r = 0; r < 4; r++) begin
        w = matrix[r*4+3];
        e = matrix[r*4+col];
        coef[r] = add ? w + e : w - e;
      end
      return coef[0]*px + coef[1]*py + coef[2]*pz + coef[3]*80'sd65536 >= 0;
    endfunction

    function void note_item(logic [1:0] op, logic [263:0] data);
      logic signed [79:0] cx, cy, cz, rad;
      bit pass_all, hit;
      cx = $signed(data[161:130]);
      cy = $signed(data[193:162]);
      cz = $signed(data[225:194]);
      rad = {49'b0, data[256:226]};
      pass_all = 1'b1;
      case (op)
        fpct_pkg::OP_LOAD: begin
          for (int c = 0; c < 4; c++) matrix[data[1:0]*4 + c] = data[2+32*c +: 32];
        end
        fpct_pkg::OP_POINT: begin
          for (int col = 0; col < 3; col++)
            for (int s = 0; s < 2; s++)
              pass_all &= plane_passes(col, s[0], cx, cy, cz);
          expected_inside.push_back(pass_all);
        end
        fpct_pkg::OP_CUBE: begin
          for (int col = 0; col < 3; col++) begin
            for (int s = 0; s < 2; s++) begin
              hit = 1'b0;
              for (int c = 0; c < 8; c++)
                hit |= plane_passes(col, s[0], (c & 1) ? cx + rad : cx - rad,
                                    (c & 2) ? cy + rad : cy - rad,
                                    (c & 4) ? cz + rad : cz - rad);
              pass_all &= hit;
            end
          end
          expected_inside.push_back(pass_all);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [7:0] tdata);
      bit want;
      if (expected_inside.size() == 0) begin
        $display("%0t: unexpected result, actual inside_res %0b", $time, tdata[0]);
        errors++;
        return;
      end
      want = expected_inside.pop_front();
      if (tdata[0] !== want) begin
        $display("%0t: inside_res mismatch, expected %0b actual %0b", $time, want, tdata[0]);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [263:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  bit           calm = 1'b0;

  cull_scoreboard sb = new();

  frustum_plane_cull_test DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 17);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  function automatic logic [263:0] pack_item(logic [1:0] row, logic [31:0] c1,
      logic [31:0] c2, logic [31:0] c3, logic [31:0] c4, logic [31:0] x,
      logic [31:0] y, logic [31:0] z, logic [30:0] hs);
    return {7'b0, hs, z, y, x, c4, c3, c2, c1, row};
  endfunction

  function automatic logic [31:0] rand_coord(bit wide);
    if (wide) return $urandom();
    return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  function automatic logic [30:0] rand_half(bit wide);
    if (wide) return 31'($urandom());
    case ($urandom_range(3))
      0: return '0;
      1: return 31'($urandom_range(0, 1 << 18));
      default: return 31'($urandom_range(0, 1 << 16));
    endcase
  endfunction

  // Small entries with a positive w offset give a frustum of a few units.
  function automatic logic [31:0] scene_elem(int r, int c, bit wide);
    if (wide) return $urandom();
    if (r == 3 && c == 3) return 32'($urandom_range(1 << 16, 4 << 16));
    return 32'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [263:0] data);
    while (!calm && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(op, data);
  endtask

  task automatic load_row(input logic [1:0] row, input logic [31:0] c1,
      input logic [31:0] c2, input logic [31:0] c3, input logic [31:0] c4);
    send_item(fpct_pkg::OP_LOAD, pack_item(row, c1, c2, c3, c4, $urandom(), $urandom(),
                                           $urandom(), 31'($urandom())));
  endtask

  task automatic test_item(input logic [1:0] op, input logic [31:0] x,
      input logic [31:0] y, input logic [31:0] z, input logic [30:0] hs);
    send_item(op, pack_item(2'($urandom()), $urandom(), $urandom(), $urandom(),
                            $urandom(), x, y, z, hs));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int sent, pick, n_tests, next_drain;
    bit wide_mat, wide_pos;
    logic [31:0] e [4];

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // With the matrix all zero every dot value is zero, so every test passes.
    test_item(fpct_pkg::OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h0);
    test_item(fpct_pkg::OP_CUBE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              31'h7FFF_FFFF);
    send_item(OP_UNUSED, '1);
    // Unit matrix: the frustum is the cube from -1 to 1 on each axis.
    for (int r = 0; r < 4; r++)
      load_row(2'(r), (r == 0) ? ONE : 32'h0, (r == 1) ? ONE : 32'h0,
               (r == 2) ? ONE : 32'h0, (r == 3) ? ONE : 32'h0);
    test_item(fpct_pkg::OP_POINT, 32'h0, 32'h0, 32'h0, 31'h0);
    test_item(fpct_pkg::OP_POINT, ONE, -ONE, ONE, 31'h0);
    test_item(fpct_pkg::OP_POINT, ONE + 1, 32'h0, 32'h0, 31'h0);
    test_item(fpct_pkg::OP_POINT, 32'h0, 32'h0, -ONE - 1, 31'h0);
    test_item(fpct_pkg::OP_CUBE, 3 * ONE, 32'h0, 32'h0, 31'(ONE + ONE / 2));
    test_item(fpct_pkg::OP_CUBE, 3 * ONE, 32'h0, 32'h0, 31'(2 * ONE));
    test_item(fpct_pkg::OP_CUBE, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
    load_row(2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    load_row(2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    test_item(fpct_pkg::OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
    test_item(fpct_pkg::OP_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0);
    test_item(fpct_pkg::OP_CUBE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              31'h7FFF_FFFF);
    test_item(fpct_pkg::OP_CUBE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              31'h7FFF_FFFF);
    load_row(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    load_row(2'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    test_item(fpct_pkg::OP_CUBE, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 31'h0);
    test_item(fpct_pkg::OP_POINT, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 31'h0);
    wait_drained();

    sent = 0;
    next_drain = 450;
    while (sent < NUM_ITEMS) begin
      calm = (sent >= 700 && sent < 1000);
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += 450;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        wide_mat = ($urandom_range(4) == 0);
        if ($urandom_range(5) != 0) begin
          for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) e[c] = scene_elem(r, c, wide_mat);
            load_row(2'(r), e[0], e[1], e[2], e[3]);
          end
          sent += 4;
        end
        n_tests = $urandom_range(2, 8);
        for (int t = 0; t < n_tests; t++) begin
          wide_pos = ($urandom_range(5) == 0);
          test_item($urandom_range(1) ? fpct_pkg::OP_POINT : fpct_pkg::OP_CUBE,
                    rand_coord(wide_pos), rand_coord(wide_pos), rand_coord(wide_pos),
                    rand_half(wide_pos));
        end
        sent += n_tests;
      end else if (pick < 75) begin
        load_row(2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
        sent++;
      end else if (pick < 95) begin
        test_item($urandom_range(1) ? fpct_pkg::OP_POINT : fpct_pkg::OP_CUBE,
                  $urandom(), $urandom(), $urandom(), 31'($urandom()));
        sent++;
      end else begin
        send_item(OP_UNUSED, {$urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom(), $urandom(),
                              8'($urandom())});
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (150) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
